### rtl/core/jst_pkg.sv
// Shared types and constants of the job status table.
// No dependencies; all files but jst_ram use this package, by scoped names or by import.
`timescale 1ns / 1ps

package jst_pkg;

	localparam int JOB_SLOTS = 4096;
	localparam int JOB_AW    = 12;
	localparam int CNT_W     = 13;
	localparam int NUM_CNT   = 7;

	localparam logic [JOB_AW:0]  SLOT_END   = 13'd4096;
	localparam logic [CNT_W-1:0] SLOT_COUNT = 13'd4096;

	// status codes held in the store
	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_RUNNING  = 3'd1;
	localparam logic [2:0] ST_RETURNED = 3'd2;
	localparam logic [2:0] ST_CANCELED = 3'd3;
	localparam logic [2:0] ST_FAILED   = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;
	localparam logic [2:0] ST_BORROWED = 3'd6;
	localparam logic [2:0] ST_ABSENT   = 3'd7;
	localparam logic [2:0] NOT_FOUND   = 3'd6;

	// opcodes
	localparam logic [3:0] OP_CHANGE  = 4'd0;
	localparam logic [3:0] OP_SET     = 4'd1;
	localparam logic [3:0] OP_QUERY   = 4'd2;
	localparam logic [3:0] OP_TAKE    = 4'd3;
	localparam logic [3:0] OP_BORROW  = 4'd4;
	localparam logic [3:0] OP_GIVE    = 4'd5;
	localparam logic [3:0] OP_RANGE   = 4'd6;
	localparam logic [3:0] OP_RECYCLE = 4'd7;
	localparam logic [3:0] OP_CLEAR   = 4'd8;
	localparam logic [3:0] OP_STAT    = 4'd9;

	typedef struct packed {
		logic [3:0]        opcode;
		logic [JOB_AW-1:0] job_number;
		logic [JOB_AW-1:0] range_end;
		logic [2:0]        new_status;
	} in_item_t;

	typedef struct packed {
		logic [JOB_AW-1:0] found_job;
		logic [2:0]        prior_status;
		logic              invalid_change;
		logic [CNT_W-1:0]  status_count;
	} out_item_t;

	typedef enum logic [2:0] {
		CL_POINT,
		CL_SEARCH,
		CL_RANGE,
		CL_RECYCLE,
		CL_CLEAR,
		CL_COUNT,
		CL_FIRST,
		CL_NONE
	} cls_t;

	typedef struct packed {
		in_item_t item;
		cls_t     cls;
	} cmd_t;

endpackage

### rtl/core/jst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module jst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/jst_front.sv
// Front end: accepts items, classifies them, holds them in a two-entry queue.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  jst_pkg::in_item_t cmd,
	output logic              head_valid,
	output jst_pkg::cmd_t     head,
	input  logic              pop
);

	jst_pkg::cmd_t ent_q [2];
	logic [1:0]    fill_q;
	logic          rd_q;
	logic          push;
	logic          wr_sel;

	function automatic jst_pkg::cls_t classify(input jst_pkg::in_item_t it);
		jst_pkg::cls_t c;
		c = jst_pkg::CL_NONE;
		unique case (it.opcode)
			jst_pkg::OP_CHANGE, jst_pkg::OP_SET, jst_pkg::OP_QUERY,
			jst_pkg::OP_GIVE:    c = jst_pkg::CL_POINT;
			jst_pkg::OP_TAKE,
			jst_pkg::OP_BORROW:  c = jst_pkg::CL_SEARCH;
			jst_pkg::OP_RANGE:   c = jst_pkg::CL_RANGE;
			jst_pkg::OP_RECYCLE: c = jst_pkg::CL_RECYCLE;
			jst_pkg::OP_CLEAR:   c = jst_pkg::CL_CLEAR;
			jst_pkg::OP_STAT:    c = (it.range_end == '0) ? jst_pkg::CL_COUNT
				: jst_pkg::CL_FIRST;
			default:             c = jst_pkg::CL_NONE;
		endcase
		return c;
	endfunction

	assign cmd_stall  = (fill_q == 2'd2);
	assign push       = cmd_valid && !cmd_stall;
	assign head_valid = (fill_q != 2'd0);
	assign head       = ent_q[rd_q];
	assign wr_sel     = rd_q ^ fill_q[0];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_sel] <= '{item: cmd, cls: classify(cmd)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			rd_q   <= 1'b0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### rtl/core/jst_engine.sv
// Back end: executes classified items against the status store and counters.
// Depends on jst_pkg and jst_ram.
`timescale 1ns / 1ps

module jst_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jst_pkg::cmd_t      head,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output jst_pkg::out_item_t rsp
);

	typedef enum logic [1:0] {S_CLR, S_IDLE, S_POINT, S_SCAN} state_t;
	typedef enum logic [1:0] {M_SEARCH, M_RECYC, M_RANGE, M_FIRST} mode_t;

	typedef struct packed {
		logic       wr;
		logic [2:0] code;
		logic       pull;
		logic [2:0] prior;
		logic       inv;
	} pt_res_t;

	state_t                        state_q;
	mode_t                         mode_q;
	jst_pkg::in_item_t             cmd_q;
	logic [jst_pkg::JOB_AW-1:0]    cursor_q;
	logic [jst_pkg::CNT_W-1:0]     cnt_q [jst_pkg::NUM_CNT];
	logic [jst_pkg::JOB_AW:0]      rd_k_q;
	logic [jst_pkg::JOB_AW:0]      end_q;
	logic                          dv_s1;
	logic [jst_pkg::JOB_AW-1:0]    k_s1;
	logic                          any_q;
	logic                          retry_q;
	logic                          from_search_q;
	logic [jst_pkg::JOB_AW-1:0]    clr_k_q;
	logic                          clr_cnt;

	logic                          we;
	logic [jst_pkg::JOB_AW-1:0]    waddr;
	logic [2:0]                    wdata;
	logic [jst_pkg::JOB_AW-1:0]    raddr;
	logic [2:0]                    rdata;
	logic                          cnt_upd;
	pt_res_t                       pt;
	logic [jst_pkg::CNT_W-1:0]     used;
	logic [jst_pkg::CNT_W-1:0]     count_val;
	logic [2:0]                    target;
	logic                          hit;

	function automatic logic [2:0] shown(input logic [2:0] s);
		logic [2:0] r;
		r = s;
		if (s == jst_pkg::ST_BORROWED) r = jst_pkg::ST_PENDING;
		if (s == jst_pkg::ST_ABSENT)   r = jst_pkg::NOT_FOUND;
		return r;
	endfunction

	function automatic pt_res_t point_eval(input logic [3:0] op, input logic [2:0] ns,
		input logic [2:0] cur);
		pt_res_t r;
		logic    bad;
		r   = '0;
		bad = 1'b0;
		unique case (op)
			jst_pkg::OP_CHANGE: begin
				r.prior = cur;
				unique case (ns)
					jst_pkg::ST_PENDING: begin
						if (cur == jst_pkg::ST_ABSENT) begin
							r.wr = 1'b1; r.pull = 1'b1; r.prior = jst_pkg::NOT_FOUND;
						end else if (cur == jst_pkg::ST_RETURNED || cur == jst_pkg::ST_RUNNING) begin
							r.wr = 1'b1; r.pull = 1'b1;
						end else bad = 1'b1;
					end
					jst_pkg::ST_RUNNING: begin
						if (cur == jst_pkg::ST_CANCELED) r.wr = 1'b0;
						else if (cur == jst_pkg::ST_PENDING || cur == jst_pkg::ST_RETURNED) begin
							r.wr = 1'b1; r.pull = (cur == jst_pkg::ST_PENDING);
						end else bad = 1'b1;
					end
					jst_pkg::ST_RETURNED: begin
						if (cur == jst_pkg::ST_RUNNING) r.wr = 1'b1;
						else if (cur < jst_pkg::ST_RETURNED || cur > jst_pkg::ST_DONE) bad = 1'b1;
					end
					jst_pkg::ST_CANCELED: begin
						if (cur <= jst_pkg::ST_RETURNED) begin
							r.wr = 1'b1; r.pull = (cur == jst_pkg::ST_PENDING);
						end else r.prior = jst_pkg::ST_CANCELED;
					end
					jst_pkg::ST_FAILED: begin
						if (cur == jst_pkg::ST_RUNNING || cur == jst_pkg::ST_RETURNED) r.wr = 1'b1;
						else r.prior = jst_pkg::ST_FAILED;
					end
					jst_pkg::ST_DONE: begin
						if (cur <= jst_pkg::ST_RETURNED) r.wr = 1'b1;
						else if (cur != jst_pkg::ST_CANCELED && cur != jst_pkg::ST_FAILED) bad = 1'b1;
					end
					default: bad = 1'b1;
				endcase
				r.code = ns;
			end
			jst_pkg::OP_SET: begin
				r.wr    = 1'b1;
				r.code  = (ns <= jst_pkg::ST_DONE) ? ns : jst_pkg::ST_ABSENT;
				r.prior = shown(cur);
			end
			jst_pkg::OP_GIVE: begin
				if (cur != jst_pkg::ST_BORROWED || ns > jst_pkg::ST_DONE) bad = 1'b1;
				else begin
					r.wr = 1'b1; r.code = ns; r.pull = (ns == jst_pkg::ST_PENDING);
					r.prior = jst_pkg::ST_PENDING;
				end
			end
			default: r.prior = shown(cur);
		endcase
		if (bad) begin
			r.wr = 1'b0; r.pull = 1'b0; r.inv = 1'b1; r.prior = shown(cur);
		end
		return r;
	endfunction

	jst_ram #(
		.WIDTH(3),
		.DEPTH(jst_pkg::JOB_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pop       = (state_q == S_IDLE) && head_valid && !rsp_valid;
	assign raddr     = (state_q == S_SCAN) ? rd_k_q[jst_pkg::JOB_AW-1:0] : head.item.job_number;
	assign pt        = point_eval(cmd_q.opcode, cmd_q.new_status, rdata);
	assign target    = (cmd_q.opcode == jst_pkg::OP_TAKE) ? jst_pkg::ST_RUNNING
		: jst_pkg::ST_BORROWED;

	always_comb begin
		hit = 1'b0;
		if (dv_s1) begin
			unique case (mode_q)
				M_SEARCH: hit = (rdata == jst_pkg::ST_PENDING);
				M_FIRST:  hit = (rdata == cmd_q.new_status);
				default:  hit = 1'b0;
			endcase
		end
	end

	// store write port
	always_comb begin
		we      = 1'b0;
		waddr   = k_s1;
		wdata   = jst_pkg::ST_PENDING;
		cnt_upd = 1'b0;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1; waddr = clr_k_q; wdata = jst_pkg::ST_ABSENT;
			end
			S_POINT: begin
				we = pt.wr; waddr = cmd_q.job_number; wdata = pt.code; cnt_upd = pt.wr;
			end
			S_SCAN: begin
				if (dv_s1) begin
					unique case (mode_q)
						M_SEARCH: begin we = hit; wdata = target; end
						M_RECYC:  we = (rdata == jst_pkg::ST_RETURNED);
						M_RANGE:  we = 1'b1;
						default:  we = 1'b0;
					endcase
				end
				cnt_upd = we;
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		used = '0;
		for (int i = 0; i < jst_pkg::NUM_CNT; i++) begin
			used = used + cnt_q[i];
		end
		if (head.item.new_status == jst_pkg::ST_ABSENT) begin
			count_val = jst_pkg::SLOT_COUNT - used;
		end else if (head.item.new_status == jst_pkg::ST_PENDING) begin
			count_val = cnt_q[jst_pkg::ST_PENDING] + cnt_q[jst_pkg::ST_BORROWED];
		end else begin
			count_val = cnt_q[head.item.new_status];
		end
	end

	assign clr_cnt = pop && (head.cls == jst_pkg::CL_CLEAR);

	// per-status counters: one down, one up per store write, but absent has none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jst_pkg::NUM_CNT; i++) cnt_q[i] <= '0;
		end else if (clr_cnt) begin
			for (int i = 0; i < jst_pkg::NUM_CNT; i++) cnt_q[i] <= '0;
		end else if (cnt_upd) begin
			for (int i = 0; i < jst_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= cnt_q[i]
					+ {{(jst_pkg::CNT_W-1){1'b0}}, (wdata == 3'(i))}
					- {{(jst_pkg::CNT_W-1){1'b0}}, (rdata == 3'(i))};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			mode_q        <= M_SEARCH;
			cursor_q      <= '0;
			rd_k_q        <= '0;
			end_q         <= '0;
			dv_s1         <= 1'b0;
			k_s1          <= '0;
			any_q         <= 1'b0;
			retry_q       <= 1'b0;
			from_search_q <= 1'b0;
			clr_k_q       <= '0;
			rsp_valid     <= 1'b0;
			rsp           <= '0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_k_q <= clr_k_q + 1'b1;
					if (clr_k_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						dv_s1         <= 1'b0;
						any_q         <= 1'b0;
						retry_q       <= 1'b0;
						from_search_q <= 1'b0;
						unique case (head.cls)
							jst_pkg::CL_POINT: state_q <= S_POINT;
							jst_pkg::CL_SEARCH: begin
								state_q       <= S_SCAN;
								mode_q        <= M_SEARCH;
								from_search_q <= 1'b1;
								rd_k_q        <= {1'b0, cursor_q} + 1'b1;
								end_q         <= jst_pkg::SLOT_END;
							end
							jst_pkg::CL_RANGE: begin
								state_q <= S_SCAN;
								mode_q  <= M_RANGE;
								rd_k_q  <= {1'b0, head.item.job_number};
								end_q   <= {1'b0, head.item.range_end} + 1'b1;
							end
							jst_pkg::CL_RECYCLE: begin
								state_q <= S_SCAN;
								mode_q  <= M_RECYC;
								rd_k_q  <= '0;
								end_q   <= jst_pkg::SLOT_END;
							end
							jst_pkg::CL_FIRST: begin
								state_q <= S_SCAN;
								mode_q  <= M_FIRST;
								rd_k_q  <= '0;
								end_q   <= jst_pkg::SLOT_END;
							end
							jst_pkg::CL_CLEAR: begin
								// answer at once; the clearing pass holds the next item
								state_q   <= S_CLR;
								clr_k_q   <= '0;
								rsp_valid <= 1'b1;
								rsp       <= '0;
							end
							jst_pkg::CL_COUNT: begin
								rsp_valid <= 1'b1;
								rsp       <= '{found_job: '0, prior_status: '0,
									invalid_change: 1'b0, status_count: count_val};
							end
							default: begin
								rsp_valid <= 1'b1;
								rsp       <= '0;
							end
						endcase
					end
				end
				S_POINT: begin
					if (pt.pull && cmd_q.job_number < cursor_q) begin
						cursor_q <= (cmd_q.job_number != '0) ? cmd_q.job_number - 1'b1 : '0;
					end
					rsp_valid <= 1'b1;
					rsp       <= '{found_job: '0, prior_status: pt.prior,
						invalid_change: pt.inv, status_count: '0};
					state_q   <= S_IDLE;
				end
				S_SCAN: begin
					if (dv_s1 && mode_q == M_RECYC && rdata == jst_pkg::ST_RETURNED) begin
						any_q <= 1'b1;
					end
					if (hit) begin
						// stop on first match; drop the read still in flight
						dv_s1     <= 1'b0;
						state_q   <= S_IDLE;
						rsp_valid <= 1'b1;
						if (mode_q == M_SEARCH) begin
							cursor_q <= k_s1;
							rsp      <= '{found_job: k_s1, prior_status: jst_pkg::ST_PENDING,
								invalid_change: 1'b0, status_count: '0};
						end else begin
							rsp      <= '{found_job: k_s1, prior_status: cmd_q.new_status,
								invalid_change: 1'b0, status_count: '0};
						end
					end else if (rd_k_q < end_q) begin
						rd_k_q <= rd_k_q + 1'b1;
						k_s1   <= rd_k_q[jst_pkg::JOB_AW-1:0];
						dv_s1  <= 1'b1;
					end else if (dv_s1) begin
						dv_s1 <= 1'b0;
					end else begin
						unique case (mode_q)
							M_SEARCH: begin
								if (!retry_q) begin
									mode_q <= M_RECYC;
									any_q  <= 1'b0;
									rd_k_q <= '0;
									end_q  <= jst_pkg::SLOT_END;
								end else begin
									state_q   <= S_IDLE;
									rsp_valid <= 1'b1;
									rsp       <= '{found_job: '0, prior_status: jst_pkg::NOT_FOUND,
										invalid_change: 1'b0, status_count: '0};
								end
							end
							M_RECYC: begin
								if (any_q) begin
									cursor_q <= '0;
								end
								if (from_search_q && any_q) begin
									// retry the search once from the bottom
									mode_q  <= M_SEARCH;
									retry_q <= 1'b1;
									rd_k_q  <= {{jst_pkg::JOB_AW{1'b0}}, 1'b1};
									end_q   <= jst_pkg::SLOT_END;
								end else begin
									state_q   <= S_IDLE;
									rsp_valid <= 1'b1;
									rsp       <= '{found_job: '0,
										prior_status: from_search_q ? jst_pkg::NOT_FOUND : 3'd0,
										invalid_change: 1'b0, status_count: '0};
								end
							end
							M_RANGE: begin
								state_q   <= S_IDLE;
								rsp_valid <= 1'b1;
								rsp       <= '0;
							end
							default: begin
								state_q   <= S_IDLE;
								rsp_valid <= 1'b1;
								rsp       <= '{found_job: '0, prior_status: jst_pkg::NOT_FOUND,
									invalid_change: 1'b0, status_count: '0};
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/job_status_table.sv
// Job status table: top level over jst_front, jst_engine (jst_ram below it), jst_pkg.
// Point items answer from S_POINT after the store read; counts, unknown opcodes answer on pop.
// Scans walk the store one job a cycle; a take/borrow may walk it thrice (recycle, retry).
// One item in the engine at a time; the next is popped when idle and its result is taken.
// Reset: a clearing pass over all 4096 jobs marks every job absent; a clear item repeats it.
// Input is queued two deep, so items are accepted while a result waits.
`timescale 1ns / 1ps

module job_status_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  jst_pkg::in_item_t  cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output jst_pkg::out_item_t rsp
);

	logic          head_valid;
	jst_pkg::cmd_t head;
	logic          pop;

	// accept and classify items, hold them until the engine is free
	jst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// run each item against the store; the result register sits in the engine
	jst_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### rtl/core/jst_checker.sv
// Port-level checks for the job status table, bound to the top level.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input jst_pkg::in_item_t  cmd,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input jst_pkg::out_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_inv_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.invalid_change |-> rsp.found_job == '0 && rsp.status_count == '0)
		else $error("refused change carries job or count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found_job != '0 |-> rsp.invalid_change == 1'b0
			&& rsp.status_count == '0)
		else $error("found job with stray fields");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status_count <= jst_pkg::SLOT_COUNT)
		else $error("count above slot total");

endmodule

bind job_status_table jst_checker u_jst_checker (.*);

### tb/sv/jst_scoreboard.sv
// Checker for the job status table: watches both channels, keeps its own copy
// of the job table and compares every result item. Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  jst_pkg::in_item_t  cmd,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  jst_pkg::out_item_t rsp,
	output int                 fail_count,
	output int                 awaiting
);
	import jst_pkg::*;

	logic [2:0] job_tbl [JOB_SLOTS];
	int         cursor;
	int         tally [NUM_CNT];
	out_item_t  due_rsp_q [$];

	function automatic logic [2:0] visible(logic [2:0] s);
		if (s == ST_BORROWED) return ST_PENDING;
		if (s == ST_ABSENT) return NOT_FOUND;
		return s;
	endfunction

	function automatic void store_status(int j, logic [2:0] s);
		if (job_tbl[j] != ST_ABSENT) tally[job_tbl[j]]--;
		if (s != ST_ABSENT) tally[s]++;
		job_tbl[j] = s;
	endfunction

	function automatic void pull_back(int j);
		if (j < cursor) cursor = (j > 0) ? j - 1 : 0;
	endfunction

	function automatic void shift_status(int j, logic [2:0] s);
		logic [2:0] was;
		was = job_tbl[j];
		store_status(j, s);
		if (s == ST_PENDING || was == ST_PENDING) pull_back(j);
	endfunction

	function automatic void requeue_returned();
		bit any;
		any = 0;
		for (int k = 0; k < JOB_SLOTS; k++)
			if (job_tbl[k] == ST_RETURNED) begin
				store_status(k, ST_PENDING);
				any = 1;
			end
		if (any) cursor = 0;
	endfunction

	function automatic int next_pending(logic [2:0] target);
		for (int t = 0; t < 2; t++) begin
			for (int k = cursor + 1; k < JOB_SLOTS; k++)
				if (job_tbl[k] == ST_PENDING) begin
					store_status(k, target);
					cursor = k;
					return k;
				end
			requeue_returned();
		end
		return 0;
	endfunction

	// checked transition; fills prior status and the refusal flag
	function automatic void checked_change(int j, logic [2:0] ns, inout out_item_t r);
		logic [2:0] cur;
		bit bad;
		cur = job_tbl[j];
		bad = 0;
		case (ns)
			ST_PENDING: begin
				if (cur == ST_ABSENT) begin
					store_status(j, ST_PENDING);
					pull_back(j);
					r.prior_status = NOT_FOUND;
				end else if (cur == ST_RETURNED || cur == ST_RUNNING) begin
					shift_status(j, ns);
					r.prior_status = cur;
				end else bad = 1;
			end
			ST_RUNNING: begin
				if (cur == ST_CANCELED) r.prior_status = cur;
				else if (cur == ST_PENDING || cur == ST_RETURNED) begin
					shift_status(j, ns);
					r.prior_status = cur;
				end else bad = 1;
			end
			ST_RETURNED: begin
				if (cur == ST_RUNNING) begin
					shift_status(j, ns);
					r.prior_status = cur;
				end else if (cur >= ST_RETURNED && cur <= ST_DONE) r.prior_status = cur;
				else bad = 1;
			end
			ST_CANCELED: begin
				if (cur <= ST_RETURNED) begin
					shift_status(j, ns);
					r.prior_status = cur;
				end else r.prior_status = ST_CANCELED;
			end
			ST_FAILED: begin
				if (cur == ST_RUNNING || cur == ST_RETURNED) begin
					shift_status(j, ns);
					r.prior_status = cur;
				end else r.prior_status = ST_FAILED;
			end
			ST_DONE: begin
				if (cur <= ST_RETURNED) begin
					store_status(j, ST_DONE);
					r.prior_status = cur;
				end else if (cur == ST_CANCELED || cur == ST_FAILED) r.prior_status = cur;
				else bad = 1;
			end
			default: bad = 1;
		endcase
		if (bad) begin
			r.invalid_change = 1'b1;
			r.prior_status   = visible(cur);
		end
	endfunction

	function automatic out_item_t run_command(in_item_t c);
		out_item_t r;
		int j, e, used;
		r = '0;
		j = int'(c.job_number);
		e = int'(c.range_end);
		case (c.opcode)
			OP_CHANGE: checked_change(j, c.new_status, r);
			OP_SET: begin
				r.prior_status = visible(job_tbl[j]);
				store_status(j, (c.new_status <= ST_DONE) ? c.new_status : ST_ABSENT);
			end
			OP_QUERY: r.prior_status = visible(job_tbl[j]);
			OP_TAKE, OP_BORROW: begin
				r.found_job = 12'(next_pending((c.opcode == OP_TAKE) ? ST_RUNNING : ST_BORROWED));
				r.prior_status = (r.found_job != 0) ? ST_PENDING : NOT_FOUND;
			end
			OP_GIVE: begin
				if (job_tbl[j] != ST_BORROWED || c.new_status > ST_DONE) begin
					r.invalid_change = 1'b1;
					r.prior_status   = visible(job_tbl[j]);
				end else begin
					store_status(j, c.new_status);
					if (c.new_status == ST_PENDING) pull_back(j);
					r.prior_status = ST_PENDING;
				end
			end
			OP_RANGE: for (int k = j; k <= e && k < JOB_SLOTS; k++) store_status(k, ST_PENDING);
			OP_RECYCLE: requeue_returned();
			OP_CLEAR: begin
				for (int k = 0; k < JOB_SLOTS; k++) job_tbl[k] = ST_ABSENT;
				for (int k = 0; k < NUM_CNT; k++) tally[k] = 0;
			end
			OP_STAT: begin
				if (e == 0) begin
					if (c.new_status != ST_ABSENT) begin
						used = tally[c.new_status];
						if (c.new_status == ST_PENDING) used += tally[ST_BORROWED];
						r.status_count = 13'(used);
					end else begin
						used = 0;
						for (int k = 0; k < NUM_CNT; k++) used += tally[k];
						r.status_count = 13'(JOB_SLOTS - used);
					end
				end else begin
					r.prior_status = NOT_FOUND;
					for (int k = 0; k < JOB_SLOTS; k++)
						if (job_tbl[k] == c.new_status) begin
							r.found_job    = 12'(k);
							r.prior_status = c.new_status;
							break;
						end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			for (int k = 0; k < JOB_SLOTS; k++) job_tbl[k] = ST_ABSENT;
			for (int k = 0; k < NUM_CNT; k++) tally[k] = 0;
			cursor     = 0;
			fail_count = 0;
			awaiting   = 0;
			due_rsp_q.delete();
		end else begin
			if (cmd_valid && !cmd_stall) due_rsp_q.insert(due_rsp_q.size(), run_command(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp_q.size() == 0) report_mismatch("unexpected result item", 1, 0);
				else begin
					want = due_rsp_q.pop_front();
					if (rsp.found_job != want.found_job)
						report_mismatch("found_job", int'(rsp.found_job), int'(want.found_job));
					if (rsp.prior_status != want.prior_status)
						report_mismatch("prior_status", int'(rsp.prior_status),
							int'(want.prior_status));
					if (rsp.invalid_change != want.invalid_change)
						report_mismatch("invalid_change", int'(rsp.invalid_change),
							int'(want.invalid_change));
					if (rsp.status_count != want.status_count)
						report_mismatch("status_count", int'(rsp.status_count),
							int'(want.status_count));
				end
			end
			awaiting = due_rsp_q.size();
		end
	end

endmodule

### tb/sv/tb_job_status_table.sv
// Testbench top for job_status_table: drives command items in bursts, stalls
// results on its own pattern and gives the verdict. Depends on jst_pkg and jst_scoreboard.
`timescale 1ns / 1ps

module tb_job_status_table;
	import jst_pkg::*;

	// hang guard: reset clear pass plus ~500 items that may each walk the store
	// three times, with stalls, taken several times over
	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int RANDOM_ITEMS = 475;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	in_item_t  cmd;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;
	int        fail_count;
	int        awaiting;

	logic cmd_took;   // item accepted at the last rising edge
	int   burst_left;
	int   stall_left = 0;
	int   stall_mode = 0;
	int   cycles = 0;

	job_status_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	jst_scoreboard checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// record acceptance with pre-edge values so the driver can read it at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_valid && !cmd_stall;
		end
	end

	// receiver: switch between no stall, random, sparse and heavy stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = int'($urandom_range(0, 3));
			stall_left = int'($urandom_range(5, 80));
		end
		stall_left--;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= 1'($urandom_range(0, 1));
			2: rsp_stall <= ($urandom_range(0, 7) == 0);
			default: rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic in_item_t mk(logic [3:0] op, int j, int e, logic [2:0] ns);
		in_item_t it;
		it.opcode     = op;
		it.job_number = 12'(j);
		it.range_end  = 12'(e);
		it.new_status = ns;
		return it;
	endfunction

	// mostly a small window of jobs so commands keep hitting the same entries
	function automatic int pick_job();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 85) return int'($urandom_range(0, 40));
		if (r < 95) return int'($urandom_range(0, JOB_SLOTS - 1));
		return (r < 97) ? 0 : JOB_SLOTS - 1;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		int j, e;
		j = pick_job();
		e = j + int'($urandom_range(0, 12));
		if (e > JOB_SLOTS - 1) e = JOB_SLOTS - 1;
		if ($urandom_range(0, 9) == 0) e = int'($urandom_range(0, JOB_SLOTS - 1));
		it = mk(4'($urandom_range(0, 9)), j, e, 3'($urandom_range(0, 7)));
		if ($urandom_range(0, 19) == 0) it.opcode = 4'($urandom_range(10, 15));
		if (it.opcode == OP_STAT && $urandom_range(0, 1)) it.range_end = '0;
		return it;
	endfunction

	// one item, starting at a falling edge; open a new burst after a random gap
	task automatic send(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 9));
			burst_left = int'($urandom_range(1, 16));
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd       <= it;
		cmd_valid <= 1'b1;
		do @(negedge clk); while (!cmd_took);
	endtask

	// job life: mark pending, pull jobs, move them on, give them back, ask for a stat
	task automatic job_life(output int n);
		int a;
		a = int'($urandom_range(1, 36));
		send(mk(OP_RANGE, a, a + int'($urandom_range(0, 4)), ST_PENDING));
		send(mk(OP_TAKE, 0, 0, ST_PENDING));
		send(mk(OP_CHANGE, pick_job(), 0, 3'($urandom_range(0, 5))));
		send(mk(OP_BORROW, 0, 0, ST_PENDING));
		send(mk(OP_GIVE, pick_job(), 0, 3'($urandom_range(0, 7))));
		send(mk(OP_CHANGE, pick_job(), 0, ST_RETURNED));
		send(mk(OP_STAT, 0, int'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
		n = 7;
	endtask

	initial begin
		int sent, n;
		cmd_valid  = 1'b0;
		cmd        = '0;
		burst_left = 0;
		arst_n     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every opcode, each corner case
		send(mk(OP_STAT, 0, 0, ST_ABSENT));             // count absent after reset
		send(mk(OP_QUERY, JOB_SLOTS - 1, 0, ST_PENDING));
		send(mk(OP_TAKE, 0, 0, ST_PENDING));            // nothing to take
		send(mk(OP_CHANGE, 0, 0, ST_PENDING));          // absent to pending, job 0
		send(mk(OP_SET, JOB_SLOTS - 1, 0, ST_DONE));
		send(mk(OP_RANGE, 1, 10, ST_PENDING));
		send(mk(OP_RANGE, 20, 15, ST_PENDING));         // empty range
		send(mk(OP_TAKE, 0, 0, ST_PENDING));
		send(mk(OP_BORROW, 0, 0, ST_PENDING));
		send(mk(OP_GIVE, 2, 0, ST_PENDING));            // give back, cursor not pulled
		send(mk(OP_GIVE, 3, 0, ST_PENDING));            // not borrowed: refused
		send(mk(OP_CHANGE, 1, 0, ST_RETURNED));
		send(mk(OP_CHANGE, 1, 0, ST_CANCELED));         // returned job canceled
		send(mk(OP_CHANGE, 4, 0, ST_DONE));             // pending to done
		send(mk(OP_CHANGE, 5, 0, ST_ABSENT));           // refused code
		send(mk(OP_STAT, 0, 0, ST_PENDING));            // count includes borrowed
		send(mk(OP_STAT, 0, 1, ST_PENDING));            // first pending, job 0
		send(mk(OP_STAT, 0, JOB_SLOTS - 1, ST_FAILED)); // none found
		send(mk(OP_RECYCLE, 0, 0, ST_PENDING));
		send(mk(OP_SET, 7, 0, ST_BORROWED));            // set with borrowed code: absent
		send(mk(OP_RANGE, JOB_SLOTS - 4, JOB_SLOTS - 1, ST_PENDING));
		send(mk(OP_CLEAR, 0, 0, ST_PENDING));
		send(mk(OP_BORROW, 0, 0, ST_PENDING));          // empty after clear
		send(mk(4'hF, JOB_SLOTS - 1, JOB_SLOTS - 1, ST_ABSENT)); // unknown opcode

		// random: mostly job lives, the rest loose commands
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 6) begin
				job_life(n);
				sent += n;
			end else begin
				send(noise_item());
				sent++;
			end
		end
		cmd_valid <= 1'b0;

		while (awaiting != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
